FILE: hw/rtl/smcd_pkg.sv
package smcd_pkg;

	localparam int GRID_W = 49;
	localparam int GRID_N = 7;
	localparam int MAT_N  = 5;
	localparam int MAT_W  = MAT_N * MAT_N;
	localparam int ROT_N  = 4;

	typedef logic [MAT_W-1:0] mat_t;
	typedef logic [2:0] row_dist_t;
	typedef logic [MAT_N-1:0][2:0] orient_dist_t;
	typedef logic [4:0] sum_t;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_BORDER = 2'd1;
	localparam logic [1:0] STATUS_DIST   = 2'd2;

	localparam logic [ROT_N-1:0][MAT_N-1:0] CODE_ROWS = {5'h0E, 5'h12, 5'h1D, 5'h01};

	function automatic logic border_white(input logic [GRID_W-1:0] g);
		logic w;
		w = 1'b0;
		for (int y = 0; y < GRID_N; y++) begin
			for (int x = 0; x < GRID_N; x++) begin
				if (y == 0 || y == GRID_N - 1 || x == 0 || x == GRID_N - 1) begin
					w = w | g[y*GRID_N+x];
				end
			end
		end
		return w;
	endfunction

	function automatic mat_t inner_mat(input logic [GRID_W-1:0] g);
		mat_t m;
		for (int y = 0; y < MAT_N; y++) begin
			for (int x = 0; x < MAT_N; x++) begin
				m[y*MAT_N+x] = g[(y+1)*GRID_N+(x+1)];
			end
		end
		return m;
	endfunction

	function automatic mat_t rot_cw(input mat_t m);
		mat_t t;
		for (int i = 0; i < MAT_N; i++) begin
			for (int j = 0; j < MAT_N; j++) begin
				t[i*MAT_N+j] = m[(MAT_N-1-j)*MAT_N+i];
			end
		end
		return t;
	endfunction

	function automatic row_dist_t row_dist(input logic [MAT_N-1:0] r);
		row_dist_t best;
		row_dist_t d;
		logic [MAT_N-1:0] x;
		best = 3'd5;
		for (int p = 0; p < ROT_N; p++) begin
			x = r ^ CODE_ROWS[p];
			d = 3'd0;
			for (int i = 0; i < MAT_N; i++) begin
				d = d + {2'd0, x[i]};
			end
			if (d < best) begin
				best = d;
			end
		end
		return best;
	endfunction

endpackage

FILE: hw/rtl/smcd_orient_cost.sv
module smcd_orient_cost (
	input  smcd_pkg::mat_t         mat,
	output smcd_pkg::orient_dist_t cost
);

	always_comb begin
		for (int y = 0; y < smcd_pkg::MAT_N; y++) begin
			cost[y] = smcd_pkg::row_dist(mat[y*smcd_pkg::MAT_N +: smcd_pkg::MAT_N]);
		end
	end

endmodule

FILE: hw/rtl/square_marker_code_decoder.sv
// Four register stages (capture, row distances, orientation sums, select and
// id) each hold their own valid bit; an accepted request reaches out_valid
// through them in that order. One request per cycle while out_stall is low.
// A stalled stage holds; bubbles ahead of it still close up.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
module square_marker_code_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [48:0] cell_grid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [9:0]  marker_id,
	output logic [1:0]  rotation_count,
	output logic [4:0]  min_distance
);

	logic                                            v_s1, v_s2, v_s3;
	logic [smcd_pkg::GRID_W-1:0]                     grid_s1;
	logic                                            border_s2, border_s3;
	smcd_pkg::mat_t                                  inner_s2, inner_s3;
	smcd_pkg::orient_dist_t [smcd_pkg::ROT_N-1:0]    dist_s2;
	smcd_pkg::sum_t [smcd_pkg::ROT_N-1:0]            sum_s3;

	logic rdy1, rdy2, rdy3, rdy4;

	smcd_pkg::mat_t [smcd_pkg::ROT_N-1:0]         rot1;
	smcd_pkg::orient_dist_t [smcd_pkg::ROT_N-1:0] dist1;
	smcd_pkg::sum_t [smcd_pkg::ROT_N-1:0]         sum2;
	smcd_pkg::mat_t [smcd_pkg::ROT_N-1:0]         rot3;

	logic [1:0]           status3;
	logic [9:0]           id3;
	logic [1:0]           best_r3;
	smcd_pkg::sum_t       best_d3;
	smcd_pkg::mat_t       best_m3;

	assign rdy4     = !out_valid || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	always_comb begin
		rot1[0] = smcd_pkg::inner_mat(grid_s1);
		for (int r = 1; r < smcd_pkg::ROT_N; r++) begin
			rot1[r] = smcd_pkg::rot_cw(rot1[r-1]);
		end
	end

	for (genvar r = 0; r < smcd_pkg::ROT_N; r++) begin : g_orient
		smcd_orient_cost u_cost (
			.mat  (rot1[r]),
			.cost (dist1[r])
		);
	end

	always_comb begin
		for (int r = 0; r < smcd_pkg::ROT_N; r++) begin
			sum2[r] = 5'd0;
			for (int y = 0; y < smcd_pkg::MAT_N; y++) begin
				sum2[r] = sum2[r] + {2'd0, dist_s2[r][y]};
			end
		end
	end

	always_comb begin
		rot3[0] = inner_s3;
		for (int r = 1; r < smcd_pkg::ROT_N; r++) begin
			rot3[r] = smcd_pkg::rot_cw(rot3[r-1]);
		end
		best_r3 = 2'd0;
		best_d3 = sum_s3[0];
		best_m3 = rot3[0];
		for (int r = 1; r < smcd_pkg::ROT_N; r++) begin
			if (sum_s3[r] < best_d3) begin
				best_r3 = 2'(r);
				best_d3 = sum_s3[r];
				best_m3 = rot3[r];
			end
		end
		id3 = 10'd0;
		for (int y = 0; y < smcd_pkg::MAT_N; y++) begin
			id3[9-2*y] = best_m3[y*smcd_pkg::MAT_N+1];
			id3[8-2*y] = best_m3[y*smcd_pkg::MAT_N+3];
		end
		if (border_s3) begin
			status3 = smcd_pkg::STATUS_BORDER;
			id3     = 10'd0;
			best_r3 = 2'd0;
			best_d3 = 5'd0;
		end else if (best_d3 == 5'd0) begin
			status3 = smcd_pkg::STATUS_OK;
		end else begin
			status3 = smcd_pkg::STATUS_DIST;
			id3     = 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			grid_s1 <= cell_grid;
		end
		if (rdy2 && v_s1) begin
			border_s2 <= smcd_pkg::border_white(grid_s1);
			inner_s2  <= rot1[0];
			dist_s2   <= dist1;
		end
		if (rdy3 && v_s2) begin
			border_s3 <= border_s2;
			inner_s3  <= inner_s2;
			sum_s3    <= sum2;
		end
		if (rdy4 && v_s3) begin
			status         <= status3;
			marker_id      <= id3;
			rotation_count <= best_r3;
			min_distance   <= best_d3;
		end
	end

	a_border_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == smcd_pkg::STATUS_BORDER |->
			marker_id == 10'd0 && rotation_count == 2'd0 && min_distance == 5'd0)
		else $error("border reject carries nonzero fields");

	a_ok_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == smcd_pkg::STATUS_OK |-> min_distance == 5'd0)
		else $error("decoded marker with nonzero distance");

	a_fail_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == smcd_pkg::STATUS_DIST |->
			marker_id == 10'd0 && min_distance != 5'd0 && min_distance <= 5'd25)
		else $error("distance reject fields inconsistent");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && out_valid && out_stall |=> v_s3)
		else $error("stage three dropped while output stalled");

endmodule
